// ===== hdl/bilinear_grid_interpolator_top_assert.svh =====
// Assertion macros of the interpolator RTL.
`ifndef BILINEAR_GRID_INTERPOLATOR_TOP_ASSERT_SVH
`define BILINEAR_GRID_INTERPOLATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BGI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bgi assertion failed");
`define BGI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bgi assertion failed");
`else
`define BGI_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define BGI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/bgi_pkg.sv =====
// Shared types, constants and helpers of the bilinear grid interpolator.
package bgi_pkg;
   localparam int MAX_X_POINTS = 16;
   localparam int MAX_Y_POINTS = 16;
   localparam int X_IDX_W      = $clog2(MAX_X_POINTS);
   localparam int Y_IDX_W      = $clog2(MAX_Y_POINTS);
   localparam int CELL_ADDR_W  = X_IDX_W + Y_IDX_W;
   localparam int CELL_DEPTH   = MAX_X_POINTS * MAX_Y_POINTS;
   localparam int CNT_W        = 5;
   localparam int FRAC_W       = 17;
   localparam int QUO_W        = 16;
   localparam int DIV_W        = 33;
   localparam int MUL_B_W      = 33;
   localparam int PROD_W       = 50;
   localparam int ACC_W        = 67;
   localparam int SPLIT        = 25;
   localparam int PADDR_W      = 3;
   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

   typedef enum logic [1:0] {
      OP_LOAD_X    = 2'd0,
      OP_LOAD_Y    = 2'd1,
      OP_LOAD_CELL = 2'd2,
      OP_QUERY     = 2'd3
   } op_type;

   typedef enum logic {
      REG_X_COUNT = 1'b0,
      REG_Y_COUNT = 1'b1
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_FIRST,
      ST_RD_LAST,
      ST_SET_Q,
      ST_SCAN,
      ST_FRAC,
      ST_DIV_WAIT,
      ST_MAC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Limits a point count register to the range the tables support.
   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt,
                                                  input logic [CNT_W-1:0] max_cnt);
      logic [CNT_W-1:0] r;
      r = cnt;
      if (cnt < CNT_W'(2)) r = CNT_W'(2);
      else if (cnt > max_cnt) r = max_cnt;
      return r;
   endfunction
endpackage

// ===== hdl/bgi_req_if.sv =====
// Request channel interface of the interpolator.
interface bgi_req_if import bgi_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [1:0]             operation;
   logic [X_IDX_W-1:0]     row_index;
   logic [Y_IDX_W-1:0]     col_index;
   logic signed [31:0]     load_value;
   logic signed [31:0]     query_x;
   logic signed [31:0]     query_y;
   modport source (output valid, operation, row_index, col_index, load_value,
                   query_x, query_y, input ready);
   modport sink (input valid, operation, row_index, col_index, load_value,
                 query_x, query_y, output ready);
endinterface

// ===== hdl/bgi_rsp_if.sv =====
// Response channel interface of the interpolator.
interface bgi_rsp_if import bgi_pkg::*;;
   logic               valid;
   logic               ready;
   logic signed [31:0] interpolated;
   logic               out_of_range;
   logic               saturated;
   modport source (output valid, interpolated, out_of_range, saturated, input ready);
   modport sink (input valid, interpolated, out_of_range, saturated, output ready);
endinterface

// ===== hdl/bgi_csr.sv =====
// APB register file holding the axis point counts.
module bgi_csr import bgi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output logic [CNT_W-1:0]   x_count,
   output logic [CNT_W-1:0]   y_count
);
   logic [CNT_W-1:0] x_count_ff;
   logic [CNT_W-1:0] y_count_ff;
   logic             wr_en;
   reg_type          sel;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign sel    = reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_count_ff <= CNT_W'(16);
         y_count_ff <= CNT_W'(16);
      end else if (wr_en) begin
         case (sel)
            REG_X_COUNT: x_count_ff <= pwdata[CNT_W-1:0];
            REG_Y_COUNT: y_count_ff <= pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_X_COUNT: prdata = {{(32-CNT_W){1'b0}}, x_count_ff};
         REG_Y_COUNT: prdata = {{(32-CNT_W){1'b0}}, y_count_ff};
         default:     prdata = '0;
      endcase
   end

   assign x_count = x_count_ff;
   assign y_count = y_count_ff;
endmodule

// ===== hdl/bgi_div.sv =====
// Restoring divider, one quotient bit per cycle, for the axis fractions.
module bgi_div import bgi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_W-1:0]   num,
   input  logic [DIV_W-1:0]   den,
   output logic [QUO_W-1:0]   quo,
   output div_stat_type       stat
);
   logic [DIV_W:0]     rem_ff;
   logic [DIV_W-1:0]   den_ff;
   logic [QUO_W-1:0]   quo_ff;
   logic [4:0]         cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     diff;
   logic               take;

   // The dividend is below the divisor, so the shifted remainder fits.
   assign trial = {rem_ff[DIV_W-1:0], 1'b0};
   assign diff  = trial - {1'b0, den_ff};
   assign take  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'(QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, num};
         den_ff <= den;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= take ? diff : trial;
         quo_ff <= {quo_ff[QUO_W-2:0], take};
      end
   end

   assign quo       = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
endmodule

// ===== hdl/bgi_mul.sv =====
// Shared registered multiplier: unsigned weight times signed operand.
module bgi_mul import bgi_pkg::*;
(
   input  logic                      clock,
   input  logic [FRAC_W-1:0]         a,
   input  logic signed [MUL_B_W-1:0] b,
   output logic signed [PROD_W-1:0]  prod
);
   logic signed [FRAC_W+MUL_B_W:0] full;
   logic signed [PROD_W-1:0]       prod_ff;

   assign full = $signed({1'b0, a}) * b;

   always_ff @(posedge clock) begin
      prod_ff <= full[PROD_W-1:0];
   end

   assign prod = prod_ff;
endmodule

// ===== hdl/bilinear_grid_interpolator_top.sv =====
// Top level of the bilinear interpolator over a non-uniform grid.
//
// The block takes transactions on the req channel (valid/ready) and returns
// query results on the rsp channel. Operations 0, 1 and 2 write one entry of
// the x axis table, the y axis table or the cell table in the cycle they are
// accepted and return nothing. Operation 3 returns one rsp transaction.
// The APB port sets x_count and y_count; a query takes x_count when accepted
// and y_count when its x fraction is done, so write them only between queries.
//
// A query is handled one at a time by a sequencer. For each axis it reads
// the first and last point, then scans the table one point per cycle through
// the single registered read port, then forms the fraction, using the
// restoring divider when it is needed. The blend reuses one registered
// 17x33 multiplier. The next transaction is taken only after the query's
// result is in the output register. req ready is high only while idle.
// Reset clears the sequencer and the counts go to 16; table contents are
// undefined until written. A stalled result waits in the output register,
// loads are still taken, and the next query waits at its last step.
module bilinear_grid_interpolator_top import bgi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   bgi_req_if.sink            req,
   bgi_rsp_if.source          rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
`include "bilinear_grid_interpolator_top_assert.svh"

   // Register file for the two point counts.
   logic [CNT_W-1:0] x_count;
   logic [CNT_W-1:0] y_count;
   logic [CNT_W-1:0] nx;
   logic [CNT_W-1:0] ny;

   bgi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .x_count (x_count),
      .y_count (y_count)
   );

   assign nx = eff_count(x_count, CNT_W'(MAX_X_POINTS));
   assign ny = eff_count(y_count, CNT_W'(MAX_Y_POINTS));

   // Tables. Each has one write port (the load) and one registered read port.
   logic signed [31:0] x_mem [MAX_X_POINTS];
   logic signed [31:0] y_mem [MAX_Y_POINTS];
   logic signed [31:0] c_mem [CELL_DEPTH];

   state_type state_ff, state_in;

   logic                    accept;
   op_type                  req_op;
   logic [X_IDX_W-1:0]      rd_addr;
   logic [CELL_ADDR_W-1:0]  cell_addr;
   logic signed [31:0]      ax_rd_ff;
   logic signed [31:0]      cell_rd_ff;

   logic signed [31:0]      qx_ff, qy_ff;
   logic                    ax_ff;
   logic [CNT_W-1:0]        n_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic signed [31:0]      first_ff, prev_ff, qc_ff, pk_ff, pk1_ff;
   logic                    found_ff;
   logic                    oor_ff;
   logic [X_IDX_W-1:0]      k_ff;
   logic [FRAC_W-1:0]       fx_ff, fy_ff;
   logic [X_IDX_W-1:0]      xi_ff;
   logic [Y_IDX_W-1:0]      yi_ff;
   logic [3:0]              ms_ff;
   logic signed [PROD_W-1:0] inner_ff, inner0_ff, inner1_ff;
   logic signed [ACC_W-1:0] total_ff;

   logic                    rsp_valid_ff;
   logic signed [31:0]      rsp_value_ff;
   logic                    rsp_oor_ff;
   logic                    rsp_sat_ff;

   assign accept = req.valid && req.ready;
   assign req_op = op_type'(req.operation);

   always_ff @(posedge clock) begin
      if (accept && req_op == OP_LOAD_X) x_mem[req.row_index] <= req.load_value;
      if (accept && req_op == OP_LOAD_Y) y_mem[req.col_index] <= req.load_value;
      if (accept && req_op == OP_LOAD_CELL) begin
         c_mem[{req.row_index, req.col_index}] <= req.load_value;
      end
      ax_rd_ff   <= ax_ff ? y_mem[rd_addr] : x_mem[rd_addr];
      cell_rd_ff <= c_mem[cell_addr];
   end

   // Clamp of the query to the current axis, evaluated when the last point
   // arrives from the table.
   logic signed [31:0] q_cur;
   logic               below, above;
   assign q_cur = ax_ff ? qy_ff : qx_ff;
   assign below = q_cur < first_ff;
   assign above = q_cur > ax_rd_ff;

   // Interval search: prev_ff holds point cnt-2, the read data point cnt-1.
   logic match;
   assign match = (cnt_ff >= CNT_W'(2)) && (prev_ff <= qc_ff) && (ax_rd_ff > qc_ff);

   // Fraction: offset and width of the chosen interval.
   logic [DIV_W-1:0] num_s, den_s;
   logic             num_pos, den_pos, num_ge;
   logic             frac_ok;
   logic [FRAC_W-1:0] frac_val;
   div_stat_type     div_stat;
   logic [QUO_W-1:0] div_quo;
   logic             div_start;

   assign num_s   = {qc_ff[31], qc_ff} - {pk_ff[31], pk_ff};
   assign den_s   = {pk1_ff[31], pk1_ff} - {pk_ff[31], pk_ff};
   assign num_pos = !num_s[DIV_W-1] && (num_s != '0);
   assign den_pos = !den_s[DIV_W-1] && (den_s != '0);
   assign num_ge  = num_s >= den_s;

   always_comb begin
      frac_ok  = 1'b0;
      frac_val = '0;
      if (state_ff == ST_FRAC) begin
         if (!den_pos || !num_pos) begin
            frac_ok = 1'b1;
         end else if (num_ge) begin
            frac_ok  = 1'b1;
            frac_val = FRAC_ONE;
         end
      end else if (state_ff == ST_DIV_WAIT && div_stat.done) begin
         frac_ok  = 1'b1;
         frac_val = {1'b0, div_quo};
      end
   end

   bgi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_s),
      .den   (den_s),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   // Blend. Each row sum wy0*c0 + wy1*c1 is formed first, then multiplied by
   // its x weight in two halves so the multiplier stays narrow.
   logic [FRAC_W-1:0]          mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod;
   logic signed [ACC_W-1:0]    prod_ext;
   logic signed [ACC_W-1:0]    prod_hi;
   logic [FRAC_W-1:0]          wx0, wy0;

   assign wx0 = FRAC_ONE - fx_ff;
   assign wy0 = FRAC_ONE - fy_ff;
   assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
   assign prod_hi  = prod_ext <<< SPLIT;

   bgi_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // Rounding to nearest (ties up) is a floor of total plus one half.
   logic signed [ACC_W-1:0] rnd;
   logic [ACC_W-33:0]       res_wide;
   logic                    sat_hi, sat_lo;
   logic signed [31:0]      res_val;
   assign rnd      = total_ff + ACC_W'(64'h8000_0000);
   assign res_wide = rnd[ACC_W-1:32];
   assign sat_hi   = !res_wide[ACC_W-33] && (res_wide[ACC_W-34:31] != '0);
   assign sat_lo   = res_wide[ACC_W-33] && (res_wide[ACC_W-34:31] != '1);
   assign res_val  = sat_hi ? 32'sh7FFF_FFFF : (sat_lo ? 32'sh8000_0000 : res_wide[31:0]);

   logic out_free, load_out;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (accept && req_op == OP_QUERY) state_in = ST_RD_FIRST;
         ST_RD_FIRST: state_in = ST_RD_LAST;
         ST_RD_LAST:  state_in = ST_SET_Q;
         ST_SET_Q:    state_in = ST_SCAN;
         ST_SCAN:     if (cnt_ff == n_ff) state_in = ST_FRAC;
         ST_FRAC: begin
            if (frac_ok) state_in = ax_ff ? ST_MAC : ST_RD_FIRST;
            else state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: if (frac_ok) state_in = ax_ff ? ST_MAC : ST_RD_FIRST;
         ST_MAC:      if (ms_ff == 4'd9) state_in = ST_OUT;
         ST_OUT:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req.ready = 1'b0;
      rd_addr   = '0;
      cell_addr = {xi_ff, yi_ff};
      div_start = 1'b0;
      load_out  = 1'b0;
      mul_a     = wy0;
      mul_b     = {cell_rd_ff[31], cell_rd_ff};
      case (state_ff)
         ST_IDLE:    req.ready = 1'b1;
         ST_RD_LAST: rd_addr = X_IDX_W'(n_ff - CNT_W'(1));
         ST_SCAN:    rd_addr = cnt_ff[X_IDX_W-1:0];
         ST_FRAC:    div_start = !frac_ok;
         ST_MAC: begin
            case (ms_ff)
               4'd0: cell_addr = {xi_ff, yi_ff};
               4'd1: cell_addr = {xi_ff, yi_ff + Y_IDX_W'(1)};
               4'd2: cell_addr = {xi_ff + X_IDX_W'(1), yi_ff};
               4'd3: cell_addr = {xi_ff + X_IDX_W'(1), yi_ff + Y_IDX_W'(1)};
               default: cell_addr = {xi_ff, yi_ff};
            endcase
            case (ms_ff)
               4'd2, 4'd4: mul_a = fy_ff;
               4'd5: begin
                  mul_a = wx0;
                  mul_b = {{(MUL_B_W-SPLIT){1'b0}}, inner0_ff[SPLIT-1:0]};
               end
               4'd6: begin
                  mul_a = wx0;
                  mul_b = {{(MUL_B_W-PROD_W+SPLIT){inner0_ff[PROD_W-1]}},
                           inner0_ff[PROD_W-1:SPLIT]};
               end
               4'd7: begin
                  mul_a = fx_ff;
                  mul_b = {{(MUL_B_W-SPLIT){1'b0}}, inner1_ff[SPLIT-1:0]};
               end
               4'd8: begin
                  mul_a = fx_ff;
                  mul_b = {{(MUL_B_W-PROD_W+SPLIT){inner1_ff[PROD_W-1]}},
                           inner1_ff[PROD_W-1:SPLIT]};
               end
               default: mul_a = wy0;
            endcase
         end
         ST_OUT:  load_out = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // Control counters and flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff        <= 1'b0;
         cnt_ff       <= '0;
         ms_ff        <= '0;
         found_ff     <= 1'b0;
         oor_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_IDLE && accept && req_op == OP_QUERY) begin
            ax_ff  <= 1'b0;
            oor_ff <= 1'b0;
         end
         if (state_ff == ST_SET_Q) begin
            cnt_ff   <= CNT_W'(1);
            found_ff <= 1'b0;
            if (below || above) oor_ff <= 1'b1;
         end
         if (state_ff == ST_SCAN) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (match) found_ff <= 1'b1;
         end
         if (frac_ok && !ax_ff) ax_ff <= 1'b1;
         if (state_ff == ST_MAC) ms_ff <= ms_ff + 4'd1;
         else ms_ff <= '0;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept) begin
         qx_ff <= req.query_x;
         qy_ff <= req.query_y;
         n_ff  <= nx;
      end
      if (frac_ok && !ax_ff) n_ff <= ny;
      if (state_ff == ST_RD_LAST) first_ff <= ax_rd_ff;
      if (state_ff == ST_SET_Q) begin
         qc_ff <= below ? first_ff : (above ? ax_rd_ff : q_cur);
      end
      if (state_ff == ST_SCAN) begin
         prev_ff <= ax_rd_ff;
         if (match) begin
            k_ff   <= X_IDX_W'(cnt_ff - CNT_W'(2));
            pk_ff  <= prev_ff;
            pk1_ff <= ax_rd_ff;
         end else if (cnt_ff == n_ff && !found_ff) begin
            k_ff   <= X_IDX_W'(n_ff - CNT_W'(2));
            pk_ff  <= prev_ff;
            pk1_ff <= ax_rd_ff;
         end
      end
      if (frac_ok) begin
         if (ax_ff) begin
            fy_ff <= frac_val;
            yi_ff <= k_ff;
         end else begin
            fx_ff <= frac_val;
            xi_ff <= k_ff;
         end
      end
      if (state_ff == ST_MAC) begin
         case (ms_ff)
            4'd2, 4'd4: inner_ff <= prod;
            4'd3: inner0_ff <= inner_ff + prod;
            4'd5: inner1_ff <= inner_ff + prod;
            4'd6: total_ff  <= prod_ext;
            4'd7, 4'd9: total_ff <= total_ff + prod_hi;
            4'd8: total_ff  <= total_ff + prod_ext;
            default: ;
         endcase
      end
      if (load_out) begin
         rsp_value_ff <= res_val;
         rsp_oor_ff   <= oor_ff;
         rsp_sat_ff   <= sat_hi || sat_lo;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.interpolated = rsp_value_ff;
   assign rsp.out_of_range = rsp_oor_ff;
   assign rsp.saturated    = rsp_sat_ff;

   `BGI_ASSERT_NOW(a_div_start_idle, clock, reset, div_start, !div_stat.busy)
   `BGI_ASSERT_NOW(a_load_out_free, clock, reset, load_out, out_free)
   `BGI_ASSERT_NOW(a_frac_range, clock, reset, frac_ok, frac_val <= FRAC_ONE)
   `BGI_ASSERT_NOW(a_div_done_wait, clock, reset, div_stat.done, state_ff == ST_DIV_WAIT)
endmodule
